// ===== sv/battery_adc_decode_and_soc_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the battery gauge decoder
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef BATTERY_ADC_DECODE_AND_SOC_UNIT_ASSERT_SVH
`define BATTERY_ADC_DECODE_AND_SOC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BADS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BADS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bads_pkg.sv =====
// ---------------------------------------------------------------------------
// bads_pkg
// Types, scaling constants and the open-circuit-voltage curve.
// ---------------------------------------------------------------------------
package bads_pkg;

  localparam int RAW_W   = 14;
  localparam int MV_W    = 13;
  localparam int MA_W    = 14;
  localparam int PCT_W   = 7;   // curve percent, unsigned
  localparam int SOC_W   = 8;   // result percent, signed
  localparam int CODE_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam int CURVE_POINTS = 23;
  localparam int SEG_W        = $clog2(CURVE_POINTS);

  // Q0.16 scales and signed Q14.16 offsets, rounding half included
  localparam int PROD_W = 31;
  localparam logic signed [PROD_W-1:0] V_SCALE_Q16 = 31'sd17600;
  localparam logic signed [PROD_W-1:0] I_SCALE_Q16 = 31'sd48889;
  localparam logic signed [PROD_W-1:0] V_OFFSET_Q16 = 31'sd170426368; // 2600*2^16 + 2^15
  localparam logic signed [PROD_W-1:0] ROUND_Q16    = 31'sd32768;
  localparam logic [MV_W-1:0] NO_BATTERY_MV = 13'd4868;

  // Interpolation divide by reciprocal
  localparam int IPROD_W     = MV_W + PCT_W;
  localparam int RECIP_SHIFT = IPROD_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [CODE_W-1:0] STOP_CODE_RST = 3'd4;
  localparam logic [CODE_W-1:0] FULL_CODE_RST = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_CODE = 2'd1;

  localparam logic signed [SOC_W-1:0] SOC_FULL    = 8'sd100;
  localparam logic signed [SOC_W-1:0] SOC_UNKNOWN = -8'sd1;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    13'd3000, 13'd3300, 13'd3500, 13'd3610, 13'd3650, 13'd3690, 13'd3710, 13'd3730,
    13'd3750, 13'd3770, 13'd3790, 13'd3800, 13'd3820, 13'd3840, 13'd3850, 13'd3870,
    13'd3910, 13'd3950, 13'd3980, 13'd4020, 13'd4080, 13'd4110, 13'd4200};

  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd0,  7'd3,  7'd6,  7'd10, 7'd13, 7'd17, 7'd20, 7'd25,
    7'd30, 7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65,
    7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd100};

  // floor(2^RECIP_SHIFT / span) of the segment ending at each point
  localparam logic [RECIP_W-1:0] CURVE_RECIP [CURVE_POINTS] = '{
    21'd0,      21'd3495,   21'd5242,   21'd9532,   21'd26214,  21'd26214,
    21'd52428,  21'd52428,  21'd52428,  21'd52428,  21'd52428,  21'd104857,
    21'd52428,  21'd52428,  21'd104857, 21'd52428,  21'd26214,  21'd26214,
    21'd34952,  21'd26214,  21'd17476,  21'd34952,  21'd11650};

  typedef enum logic [2:0] {
    SEL_FULL,
    SEL_UNKNOWN,
    SEL_LOW,
    SEL_HIGH,
    SEL_INTERP
  } pct_sel_t;

  typedef struct packed {
    logic [CODE_W-1:0] stop_code;
    logic [CODE_W-1:0] full_code;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_voltage;
    logic [RAW_W-1:0] raw_current;
    logic [RAW_W-1:0] raw_open_voltage;
    logic [7:0]       charge_byte;
  } sample_t;

  typedef struct packed {
    logic [MV_W-1:0]        voltage_mv;
    logic signed [MA_W-1:0] current_ma;
    logic [MV_W-1:0]        open_voltage_mv;
    logic [CODE_W-1:0]      charge_state;
    logic                   eoc_flag;
  } meas_t;

  typedef struct packed {
    meas_t meas;
    logic  full_hit;
  } dec_t;

  typedef struct packed {
    meas_t              meas;
    pct_sel_t           sel;
    logic [MV_W-1:0]    diff;
    logic [PCT_W-1:0]   rise;
    logic [MV_W-1:0]    span;
    logic [RECIP_W-1:0] recip;
    logic [PCT_W-1:0]   lo_pct;
  } seg_t;

  typedef struct packed {
    meas_t                   meas;
    logic signed [SOC_W-1:0] percent;
  } res_t;

endpackage

// ===== sv/bads_scale.sv =====
// ---------------------------------------------------------------------------
// bads_scale
// Two-stage fixed-point decode of the three ADC words and the status byte.
// ---------------------------------------------------------------------------
module bads_scale
  import bads_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output dec_t    out_data
);

  typedef struct packed {
    logic signed [PROD_W-1:0] pv;
    logic signed [PROD_W-1:0] pi;
    logic signed [PROD_W-1:0] po;
    logic [CODE_W-1:0]        state;
    logic                     done;
    logic                     full_hit;
  } prod_t;

  logic  s1_v_r, s2_v_r;
  logic  s1_rdy, s2_rdy;
  prod_t s1_r, s1_nxt;
  dec_t  s2_r, s2_nxt;

  logic signed [PROD_W-1:0] sum_v, sum_i, sum_o;
  logic [MV_W-1:0]          mv_v, mv_o;

  assign s2_rdy   = !s2_v_r || out_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Stage 1: sign-extend and multiply by the Q0.16 scale
  always_comb begin
    s1_nxt.pv = PROD_W'($signed(in_data.raw_voltage)) * V_SCALE_Q16;
    s1_nxt.pi = PROD_W'($signed(in_data.raw_current)) * I_SCALE_Q16;
    s1_nxt.po = PROD_W'($signed(in_data.raw_open_voltage)) * V_SCALE_Q16;
    s1_nxt.state = in_data.charge_byte[7:5];
    s1_nxt.done  = in_data.charge_byte[3];
    s1_nxt.full_hit = (in_data.charge_byte[7:5] == cfg.stop_code) ||
                      (in_data.charge_byte[7:5] == cfg.full_code);
  end

  // Stage 2: add offset and half, drop the fraction, map the no-battery code
  always_comb begin
    sum_v = s1_r.pv + V_OFFSET_Q16;
    sum_o = s1_r.po + V_OFFSET_Q16;
    sum_i = s1_r.pi + ROUND_Q16;
    mv_v  = sum_v[16 +: MV_W];
    mv_o  = sum_o[16 +: MV_W];
    s2_nxt.meas.voltage_mv      = (mv_v == NO_BATTERY_MV) ? '0 : mv_v;
    s2_nxt.meas.open_voltage_mv = (mv_o == NO_BATTERY_MV) ? '0 : mv_o;
    s2_nxt.meas.current_ma      = sum_i[16 +: MA_W];
    s2_nxt.meas.charge_state    = s1_r.state;
    s2_nxt.meas.eoc_flag        = s1_r.done;
    s2_nxt.full_hit             = s1_r.full_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) s1_r <= s1_nxt;
    if (s2_rdy && s1_v_r)   s2_r <= s2_nxt;
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

endmodule

// ===== sv/bads_seg.sv =====
// ---------------------------------------------------------------------------
// bads_seg
// Two-stage curve segment search and segment constant fetch.
// ---------------------------------------------------------------------------
module bads_seg
  import bads_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dec_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output seg_t out_data
);

  typedef struct packed {
    meas_t            meas;
    pct_sel_t         sel;
    logic [SEG_W-1:0] idx;
  } find_t;

  logic  s3_v_r, s4_v_r;
  logic  s3_rdy, s4_rdy;
  find_t s3_r, s3_nxt;
  seg_t  s4_r, s4_nxt;

  logic [MV_W-1:0]  ocv;
  logic [SEG_W-1:0] lo_idx;

  assign s4_rdy   = !s4_v_r || out_ready;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign in_ready = s3_rdy;

  assign ocv = in_data.meas.open_voltage_mv;

  // Stage 3: classify and find the first point at or above the voltage
  always_comb begin
    s3_nxt.meas = in_data.meas;
    if (in_data.full_hit)                       s3_nxt.sel = SEL_FULL;
    else if (ocv == '0)                         s3_nxt.sel = SEL_UNKNOWN;
    else if (ocv <= CURVE_MV[0])                s3_nxt.sel = SEL_LOW;
    else if (ocv >= CURVE_MV[CURVE_POINTS-1])   s3_nxt.sel = SEL_HIGH;
    else                                        s3_nxt.sel = SEL_INTERP;
    s3_nxt.idx = SEG_W'(CURVE_POINTS - 1);
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (ocv <= CURVE_MV[i]) s3_nxt.idx = SEG_W'(i);
    end
  end

  // Stage 4: fetch the segment ends and take the offset into the segment
  assign lo_idx = s3_r.idx - SEG_W'(1);

  always_comb begin
    s4_nxt.meas   = s3_r.meas;
    s4_nxt.sel    = s3_r.sel;
    s4_nxt.diff   = s3_r.meas.open_voltage_mv - CURVE_MV[lo_idx];
    s4_nxt.span   = CURVE_MV[s3_r.idx] - CURVE_MV[lo_idx];
    s4_nxt.rise   = (CURVE_PCT[s3_r.idx] >= CURVE_PCT[lo_idx]) ?
                    (CURVE_PCT[s3_r.idx] - CURVE_PCT[lo_idx]) : '0;
    s4_nxt.recip  = CURVE_RECIP[s3_r.idx];
    s4_nxt.lo_pct = CURVE_PCT[lo_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_v_r <= in_valid;
      if (s4_rdy) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && in_valid) s3_r <= s3_nxt;
    if (s4_rdy && s3_v_r)   s4_r <= s4_nxt;
  end

  assign out_valid = s4_v_r;
  assign out_data  = s4_r;

endmodule

// ===== sv/bads_interp.sv =====
// ---------------------------------------------------------------------------
// bads_interp
// Four-stage interpolation: product, reciprocal divide, remainder fix, select.
// ---------------------------------------------------------------------------
module bads_interp
  import bads_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  seg_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  typedef struct packed {
    meas_t              meas;
    pct_sel_t           sel;
    logic [PCT_W-1:0]   lo_pct;
    logic [MV_W-1:0]    span;
    logic [RECIP_W-1:0] recip;
    logic [IPROD_W-1:0] prod;
  } mul_t;

  typedef struct packed {
    meas_t              meas;
    pct_sel_t           sel;
    logic [PCT_W-1:0]   lo_pct;
    logic [MV_W-1:0]    span;
    logic [IPROD_W-1:0] prod;
    logic [PCT_W-1:0]   quot;
  } est_t;

  typedef struct packed {
    meas_t              meas;
    pct_sel_t           sel;
    logic [PCT_W-1:0]   lo_pct;
    logic [MV_W-1:0]    span;
    logic [IPROD_W-1:0] prod;
    logic [PCT_W-1:0]   quot;
    logic [IPROD_W-1:0] back;
  } chk_t;

  localparam int EST_W = IPROD_W + RECIP_W;

  logic s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic s5_rdy, s6_rdy, s7_rdy, s8_rdy;
  mul_t s5_r, s5_nxt;
  est_t s6_r, s6_nxt;
  chk_t s7_r, s7_nxt;
  res_t s8_r, s8_nxt;

  logic [EST_W-1:0]   est;
  logic [IPROD_W-1:0] rem;
  logic               bump;
  logic [PCT_W-1:0]   interp_pct;

  assign s8_rdy   = !s8_v_r || out_ready;
  assign s7_rdy   = !s7_v_r || s8_rdy;
  assign s6_rdy   = !s6_v_r || s7_rdy;
  assign s5_rdy   = !s5_v_r || s6_rdy;
  assign in_ready = s5_rdy;

  // Stage 5: offset times rise
  always_comb begin
    s5_nxt.meas   = in_data.meas;
    s5_nxt.sel    = in_data.sel;
    s5_nxt.lo_pct = in_data.lo_pct;
    s5_nxt.span   = in_data.span;
    s5_nxt.recip  = in_data.recip;
    s5_nxt.prod   = IPROD_W'(in_data.diff) * IPROD_W'(in_data.rise);
  end

  // Stage 6: quotient estimate, low by at most one
  assign est = EST_W'(s5_r.prod) * EST_W'(s5_r.recip);

  always_comb begin
    s6_nxt.meas   = s5_r.meas;
    s6_nxt.sel    = s5_r.sel;
    s6_nxt.lo_pct = s5_r.lo_pct;
    s6_nxt.span   = s5_r.span;
    s6_nxt.prod   = s5_r.prod;
    s6_nxt.quot   = est[RECIP_SHIFT +: PCT_W];
  end

  // Stage 7: multiply the estimate back by the span
  always_comb begin
    s7_nxt.meas   = s6_r.meas;
    s7_nxt.sel    = s6_r.sel;
    s7_nxt.lo_pct = s6_r.lo_pct;
    s7_nxt.span   = s6_r.span;
    s7_nxt.prod   = s6_r.prod;
    s7_nxt.quot   = s6_r.quot;
    s7_nxt.back   = IPROD_W'(s6_r.quot) * IPROD_W'(s6_r.span);
  end

  // Stage 8: bump the estimate when a whole span is left, then pick the result
  assign rem        = s7_r.prod - s7_r.back;
  assign bump       = (s7_r.span != '0) && (rem >= IPROD_W'(s7_r.span));
  assign interp_pct = s7_r.lo_pct + s7_r.quot + PCT_W'(bump);

  always_comb begin
    s8_nxt.meas = s7_r.meas;
    case (s7_r.sel)
      SEL_FULL:    s8_nxt.percent = SOC_FULL;
      SEL_UNKNOWN: s8_nxt.percent = SOC_UNKNOWN;
      SEL_LOW:     s8_nxt.percent = SOC_W'(CURVE_PCT[0]);
      SEL_HIGH:    s8_nxt.percent = SOC_W'(CURVE_PCT[CURVE_POINTS-1]);
      SEL_INTERP:  s8_nxt.percent = SOC_W'(interp_pct);
      default:     s8_nxt.percent = SOC_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else begin
      if (s5_rdy) s5_v_r <= in_valid;
      if (s6_rdy) s6_v_r <= s5_v_r;
      if (s7_rdy) s7_v_r <= s6_v_r;
      if (s8_rdy) s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && in_valid) s5_r <= s5_nxt;
    if (s6_rdy && s5_v_r)   s6_r <= s6_nxt;
    if (s7_rdy && s6_v_r)   s7_r <= s7_nxt;
    if (s8_rdy && s7_v_r)   s8_r <= s8_nxt;
  end

  assign out_valid = s8_v_r;
  assign out_data  = s8_r;

endmodule

// ===== sv/battery_adc_decode_and_soc_unit.sv =====
// ---------------------------------------------------------------------------
// battery_adc_decode_and_soc_unit
// Battery gauge sample decoder with open-circuit-voltage state of charge.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_tvalid/in_tready  | in_tdata: three ADC words, status byte
//  out_    | output    | out_tvalid/out_tready| out_tdata: mV, mA, OCV mV, %, status
//  cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  Throughput: one sample set per cycle while out_tready does not stall. An
//  accepted input transaction reaches out_tdata through the eight register
//  stages (scale multiply, offset/round, segment search, segment fetch,
//  rise product, reciprocal multiply, back multiply, correct and select).
//  Reset (rst_n low, synchronous) clears every stage valid and loads the
//  default stop and full codes. A stall on out_tready fills empty stages
//  first; in_tready drops only once every stage holds a transaction.
// ---------------------------------------------------------------------------
module battery_adc_decode_and_soc_unit
  import bads_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // [13:0] raw_voltage, [27:14] raw_current, [41:28] raw_open_voltage,
  // [49:42] charge_byte, [55:50] zero
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [55:0]          in_tdata,
  // [12:0] voltage_mv, [26:13] current_ma, [39:27] open_voltage_mv,
  // [47:40] percent, [50:48] charge_state, [51] eoc_flag, [55:52] zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  sample_t sample;
  dec_t    dec_data;
  seg_t    seg_data;
  res_t    res_data;
  logic    dec_valid, dec_ready;
  logic    seg_valid, seg_ready;

  // Configuration writes are always taken; an unknown index writes nothing.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_STOP_CODE: cfg_nxt.stop_code = cfg_data;
        REG_FULL_CODE: cfg_nxt.full_code = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_code <= STOP_CODE_RST;
      cfg_r.full_code <= FULL_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Unpack the input transaction, first field in the low bits.
  assign sample.raw_voltage      = in_tdata[13:0];
  assign sample.raw_current      = in_tdata[27:14];
  assign sample.raw_open_voltage = in_tdata[41:28];
  assign sample.charge_byte      = in_tdata[49:42];

  // Scale the three ADC words and decode the status byte.
  bads_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (sample),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  // Locate the curve segment for the open-circuit voltage.
  bads_seg u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_data  (seg_data)
  );

  // Interpolate and pick the percent; its last stage is the output register.
  bads_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .in_data   (seg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_data)
  );

  // Pack the result transaction.
  assign out_tdata = {4'b0000,
                      res_data.meas.eoc_flag,
                      res_data.meas.charge_state,
                      res_data.percent,
                      res_data.meas.open_voltage_mv,
                      res_data.meas.current_ma,
                      res_data.meas.voltage_mv};

endmodule

// ===== sv/bads_checker.sv =====
// ---------------------------------------------------------------------------
// bads_checker
// Port-level checks on the result stream of the battery gauge decoder.
// ---------------------------------------------------------------------------
`include "battery_adc_decode_and_soc_unit_assert.svh"

module bads_checker
  import bads_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // Hold a stalled result until it is taken.
  `BADS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed or dropped")

  // Percent stays within -1 to 100.
  `BADS_ASSERT_NOW(a_pct_range, out_tvalid, (out_tdata[47:40] == 8'hFF) || (out_tdata[47:40] <= 8'd100), "percent out of range")

  // Unknown percent only comes with a zero open-circuit voltage.
  `BADS_ASSERT_NOW(a_unknown_ocv, out_tvalid && (out_tdata[47:40] == 8'hFF), out_tdata[39:27] == 13'd0, "unknown percent with nonzero open-circuit voltage")

  // Both voltages stay at or below the 4800 mV top of the ADC range.
  `BADS_ASSERT_NOW(a_mv_range, out_tvalid, (out_tdata[12:0] <= 13'd4800) && (out_tdata[39:27] <= 13'd4800), "voltage above decode range")

endmodule

bind battery_adc_decode_and_soc_unit bads_checker u_bads_checker (.*);
